>>> hw/rtl/gem_pkg.sv
package gem_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 11;
   localparam int PIXEL_W    = 8;
   localparam int MAG_W      = 8;
   localparam int MASK_ROW_W = 24;
   localparam int CSR_IDX_W  = 4;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = Q_PTR_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MASK_X_TOP,
      REG_MASK_X_MIDDLE,
      REG_MASK_X_BOTTOM,
      REG_MASK_Y_TOP,
      REG_MASK_Y_MIDDLE,
      REG_MASK_Y_BOTTOM,
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT
   } csr_index_type;

   localparam logic [MASK_ROW_W-1:0] MASK_X_TOP_RST    = 24'd65791;
   localparam logic [MASK_ROW_W-1:0] MASK_X_MIDDLE_RST = 24'd131326;
   localparam logic [MASK_ROW_W-1:0] MASK_X_BOTTOM_RST = 24'd65791;
   localparam logic [MASK_ROW_W-1:0] MASK_Y_TOP_RST    = 24'd16776959;
   localparam logic [MASK_ROW_W-1:0] MASK_Y_MIDDLE_RST = 24'd0;
   localparam logic [MASK_ROW_W-1:0] MASK_Y_BOTTOM_RST = 24'd66049;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // [row][column], row 0 is the top of the window
   typedef logic [2:0][2:0][PIXEL_W-1:0] window_type;

   typedef struct packed {
      logic [1:0][2:0][MASK_ROW_W-1:0] masks;   // [0] X mask, [1] Y mask
      logic [COL_W:0]                  width;   // already clamped
      logic [ROW_W:0]                  height;  // already clamped
   } cfg_type;

   typedef struct packed {
      window_type         window;
      logic [COL_W-1:0]   column;
      logic [ROW_W-1:0]   row;
      logic               last;
   } queue_item_type;

endpackage

>>> hw/rtl/gem_if.sv
interface gem_req_if import gem_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PIXEL_W-1:0]   pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface gem_rsp_if import gem_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MAG_W-1:0]     magnitude;
   logic [COL_W-1:0]     out_column;
   logic [ROW_W-1:0]     out_row;
   logic                 frame_last;

   modport source (output valid, output magnitude, output out_column, output out_row,
                   output frame_last, input ready);
   modport sink (input valid, input magnitude, input out_column, input out_row,
                 input frame_last, output ready);
endinterface

interface gem_csr_if import gem_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [MASK_ROW_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/gem_csr.sv
module gem_csr import gem_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [MASK_ROW_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   logic [SIZE_W-1:0] size_val;
   logic [COL_W:0]    width_clamped;
   logic [ROW_W:0]    height_clamped;

   assign size_val = wr_data[SIZE_W-1:0];

   // Store sizes clamped, so the front never sees an out-of-range frame
   always_comb begin
      if (int'(size_val) < 3) begin
         width_clamped  = (COL_W+1)'(3);
         height_clamped = (ROW_W+1)'(3);
      end else begin
         if (int'(size_val) > MAX_WIDTH) width_clamped = (COL_W+1)'(MAX_WIDTH);
         else width_clamped = (COL_W+1)'(size_val);
         if (int'(size_val) > MAX_HEIGHT) height_clamped = (ROW_W+1)'(MAX_HEIGHT);
         else height_clamped = (ROW_W+1)'(size_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.masks[0][0] <= MASK_X_TOP_RST;
         cfg_ff.masks[0][1] <= MASK_X_MIDDLE_RST;
         cfg_ff.masks[0][2] <= MASK_X_BOTTOM_RST;
         cfg_ff.masks[1][0] <= MASK_Y_TOP_RST;
         cfg_ff.masks[1][1] <= MASK_Y_MIDDLE_RST;
         cfg_ff.masks[1][2] <= MASK_Y_BOTTOM_RST;
         cfg_ff.width       <= (COL_W+1)'(MAX_WIDTH);
         cfg_ff.height      <= (ROW_W+1)'(MAX_HEIGHT);
      end else if (wr_en) begin
         case (wr_index)
            REG_MASK_X_TOP:    cfg_ff.masks[0][0] <= wr_data;
            REG_MASK_X_MIDDLE: cfg_ff.masks[0][1] <= wr_data;
            REG_MASK_X_BOTTOM: cfg_ff.masks[0][2] <= wr_data;
            REG_MASK_Y_TOP:    cfg_ff.masks[1][0] <= wr_data;
            REG_MASK_Y_MIDDLE: cfg_ff.masks[1][1] <= wr_data;
            REG_MASK_Y_BOTTOM: cfg_ff.masks[1][2] <= wr_data;
            REG_FRAME_WIDTH:   cfg_ff.width       <= width_clamped;
            REG_FRAME_HEIGHT:  cfg_ff.height      <= height_clamped;
            default: ;  // drop writes past the register list
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/gem_front.sv
module gem_front import gem_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            in_valid,
   output logic            in_ready,
   input  pixel_type       in_pixel,
   input  logic [Q_CNT_W-1:0] q_count,
   output logic            push,
   output queue_item_type  push_item
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             a_valid_ff, a_valid_in;
   pixel_type        a_pixel_ff;
   logic [COL_W-1:0] a_col_ff;
   logic [ROW_W-1:0] a_row_ff;
   logic             a_interior_ff;
   logic             a_last_ff;

   logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIXEL_W-1:0] line_rd_ff;

   window_type       window_ff, window_in;

   logic             accept;
   logic [COL_W-1:0] col_now;
   logic [ROW_W-1:0] row_now;
   logic [ROW_W:0]   row_wrap;
   logic [COL_W:0]   col_inc;
   logic [ROW_W:0]   row_inc;
   logic             interior;
   logic             last;

   // Keep room in the queue for the transaction already past the read stage
   assign in_ready = (Q_CNT_W'(q_count) + Q_CNT_W'(a_valid_ff)) < Q_CNT_W'(Q_DEPTH);
   assign accept   = in_valid && in_ready;

   // Position of this pixel, wrapped in case the frame size shrank
   always_comb begin
      row_wrap = {1'b0, row_ff};
      col_now  = col_ff;
      if ({1'b0, col_ff} >= cfg.width) begin
         col_now  = '0;
         row_wrap = {1'b0, row_ff} + (ROW_W+1)'(1);
      end
      if (row_wrap >= cfg.height) row_now = '0;
      else row_now = row_wrap[ROW_W-1:0];

      interior = (col_now >= COL_W'(2)) && (row_now >= ROW_W'(2));
      last     = ({1'b0, col_now} == cfg.width - (COL_W+1)'(1)) &&
                 ({1'b0, row_now} == cfg.height - (ROW_W+1)'(1));

      col_inc = {1'b0, col_now} + (COL_W+1)'(1);
      row_inc = {1'b0, row_now} + (ROW_W+1)'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (col_inc >= cfg.width) begin
            col_in = '0;
            if (row_inc >= cfg.height) row_in = '0;
            else row_in = row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
            row_in = row_now;
         end
      end
   end

   assign a_valid_in = accept;

   // Shift the window left and bring in the new column
   always_comb begin
      window_in = window_ff;
      for (int r = 0; r < 3; r++) begin
         window_in[r][0] = window_ff[r][1];
         window_in[r][1] = window_ff[r][2];
      end
      window_in[0][2] = line_rd_ff[2*PIXEL_W-1:PIXEL_W];
      window_in[1][2] = line_rd_ff[PIXEL_W-1:0];
      window_in[2][2] = a_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
         window_ff  <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
         if (a_valid_ff) window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pixel_ff    <= in_pixel;
         a_col_ff      <= col_now;
         a_row_ff      <= row_now;
         a_interior_ff <= interior;
         a_last_ff     <= last;
      end
   end

   // Line stores: upper row in the high byte, lower row in the low byte
   always_ff @(posedge clock) begin
      if (accept) line_rd_ff <= line_mem[col_now];
      if (a_valid_ff) line_mem[a_col_ff] <= {line_rd_ff[PIXEL_W-1:0], a_pixel_ff};
   end

   assign push             = a_valid_ff && a_interior_ff;
   assign push_item.window = window_in;
   assign push_item.column = a_col_ff - COL_W'(1);
   assign push_item.row    = a_row_ff - ROW_W'(1);
   assign push_item.last   = a_last_ff;

endmodule

>>> hw/rtl/gem_queue.sv
module gem_queue import gem_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  queue_item_type     push_item,
   input  logic               pop,
   output logic               not_empty,
   output queue_item_type     head_item,
   output logic [Q_CNT_W-1:0] count
);

   queue_item_type       entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + Q_PTR_W'(1);
      if (pop) rd_ptr_in = rd_ptr_ff + Q_PTR_W'(1);
      if (push && !pop) count_in = count_ff + Q_CNT_W'(1);
      else if (pop && !push) count_in = count_ff - Q_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

   assign not_empty = count_ff != '0;
   assign head_item = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

>>> hw/rtl/gem_back.sv
module gem_back import gem_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               q_not_empty,
   input  queue_item_type     q_head,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [MAG_W-1:0]   out_magnitude,
   output logic [COL_W-1:0]   out_column,
   output logic [ROW_W-1:0]   out_row,
   output logic               out_last
);

   localparam int PROD_W   = 2 * PIXEL_W + 1;
   localparam int ROWSUM_W = PROD_W + 2;
   localparam int GRAD_W   = ROWSUM_W + 2;
   localparam int ABS_W    = GRAD_W - 1;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             last;
   } side_type;

   logic advance;

   logic                                 s1_valid_ff;
   side_type                             s1_side_ff;
   logic signed [PROD_W-1:0]             prod_ff [2][3][3];
   logic signed [PROD_W-1:0]             prod_in [2][3][3];

   logic                                 s2_valid_ff;
   side_type                             s2_side_ff;
   logic signed [ROWSUM_W-1:0]           rowsum_ff [2][3];
   logic signed [ROWSUM_W-1:0]           rowsum_in [2][3];

   logic                                 s3_valid_ff;
   side_type                             s3_side_ff;
   logic [ABS_W-1:0]                     abs_ff [2];
   logic [ABS_W-1:0]                     abs_in [2];
   logic signed [GRAD_W-1:0]             grad [2];

   logic                                 out_valid_ff;
   logic [MAG_W-1:0]                     mag_ff;
   side_type                             out_side_ff;
   logic [GRAD_W-1:0]                    mag_sum;
   logic [MAG_W-1:0]                     mag_in;

   // Whole pipe holds while a result waits at the output
   assign advance = !out_valid_ff || out_ready;
   assign pop     = advance && q_not_empty;

   always_comb begin
      for (int m = 0; m < 2; m++)
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               prod_in[m][r][c] =
                  $signed(cfg.masks[m][r][8*c +: 8]) *
                  $signed({1'b0, q_head.window[r][c]});
   end

   always_comb begin
      for (int m = 0; m < 2; m++)
         for (int r = 0; r < 3; r++)
            rowsum_in[m][r] = ROWSUM_W'(prod_ff[m][r][0]) + ROWSUM_W'(prod_ff[m][r][1])
                              + ROWSUM_W'(prod_ff[m][r][2]);
   end

   always_comb begin
      for (int m = 0; m < 2; m++) begin
         grad[m] = GRAD_W'(rowsum_ff[m][0]) + GRAD_W'(rowsum_ff[m][1])
                   + GRAD_W'(rowsum_ff[m][2]);
         if (grad[m][GRAD_W-1]) abs_in[m] = ABS_W'(-grad[m]);
         else abs_in[m] = ABS_W'(grad[m]);
      end
   end

   // Saturate the magnitude to a full-scale pixel
   always_comb begin
      mag_sum = {1'b0, abs_ff[0]} + {1'b0, abs_ff[1]};
      if (mag_sum > GRAD_W'(255)) mag_in = '1;
      else mag_in = mag_sum[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= q_not_empty;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_side_ff.column <= q_head.column;
         s1_side_ff.row    <= q_head.row;
         s1_side_ff.last   <= q_head.last;
         prod_ff           <= prod_in;
         s2_side_ff        <= s1_side_ff;
         rowsum_ff         <= rowsum_in;
         s3_side_ff        <= s2_side_ff;
         abs_ff            <= abs_in;
         out_side_ff       <= s3_side_ff;
         mag_ff            <= mag_in;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_magnitude = mag_ff;
   assign out_column    = out_side_ff.column;
   assign out_row       = out_side_ff.row;
   assign out_last      = out_side_ff.last;

endmodule

>>> hw/rtl/gradient_edge_magnitude_3x3_core.sv
// Path: a result follows the transaction of the pixel below and right of its centre
// through the front register, the queue, stages s1 to s3 and the output register, held while the result channel stalls.
// Throughput: one pixel per cycle while the queue has room; the line store takes one read
// and one write a cycle. A four-entry queue between window front and correlation pipe
// absorbs result stalls. Reset: position, window and pipe cleared, masks and frame size to
// defaults; line store contents are not cleared.
module gradient_edge_magnitude_3x3_core import gem_pkg::*; (
   input logic      clock,
   input logic      reset,
   gem_req_if.sink  req_ch,
   gem_rsp_if.source rsp_ch,
   gem_csr_if.sink  csr_ch
);

   cfg_type              cfg;
   logic                 q_push;
   queue_item_type       q_push_item;
   logic                 q_pop;
   logic                 q_not_empty;
   queue_item_type       q_head;
   logic [Q_CNT_W-1:0]   q_count;

   assign csr_ch.ready = 1'b1;

   gem_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   gem_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_pixel  (req_ch.pixel),
      .q_count   (q_count),
      .push      (q_push),
      .push_item (q_push_item)
   );

   gem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (q_head),
      .count     (q_count)
   );

   gem_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .pop           (q_pop),
      .out_valid     (rsp_ch.valid),
      .out_ready     (rsp_ch.ready),
      .out_magnitude (rsp_ch.magnitude),
      .out_column    (rsp_ch.out_column),
      .out_row       (rsp_ch.out_row),
      .out_last      (rsp_ch.frame_last)
   );

endmodule

>>> bench/gradient_edge_magnitude_3x3_core_tb.sv
`timescale 1ns / 100ps

module gradient_edge_magnitude_3x3_core_tb;
   import gem_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int PIXELS_PER_MODE = 300;
   localparam int SMALL_SIDE     = 12;
   localparam int WIDE_SIDE      = 150;
   localparam int TALL_ROWS      = 80;
   localparam logic [CSR_IDX_W-1:0] FIRST_SPARE_INDEX =
      CSR_IDX_W'(int'(REG_FRAME_HEIGHT) + 1);

   typedef enum {MASK_SOBEL, MASK_SMALL, MASK_WIDE, MASK_EXTREME} mask_style_type;
   typedef enum {PIXEL_NOISE, PIXEL_SMOOTH, PIXEL_BINARY} pixel_style_type;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             last;
   } edge_result_type;

   class edge_magnitude_board;
      logic [MASK_ROW_W-1:0] mask_rows [6];
      logic [SIZE_W-1:0]     width_reg;
      logic [SIZE_W-1:0]     height_reg;
      pixel_type             upper_line [MAX_WIDTH];
      pixel_type             lower_line [MAX_WIDTH];
      pixel_type             window [3][3];
      int                    next_column;
      int                    next_row;
      edge_result_type       expected_edges [$];
      int                    mismatches;

      function new();
         mask_rows[0] = MASK_X_TOP_RST;
         mask_rows[1] = MASK_X_MIDDLE_RST;
         mask_rows[2] = MASK_X_BOTTOM_RST;
         mask_rows[3] = MASK_Y_TOP_RST;
         mask_rows[4] = MASK_Y_MIDDLE_RST;
         mask_rows[5] = MASK_Y_BOTTOM_RST;
         width_reg  = SIZE_W'(MAX_WIDTH);
         height_reg = SIZE_W'(MAX_HEIGHT);
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
         end
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               window[r][c] = '0;
            end
         end
         next_column = 0;
         next_row    = 0;
         mismatches  = 0;
      endfunction

      function int span_width();
         if (width_reg < 3) return 3;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return int'(width_reg);
      endfunction

      function int span_height();
         if (height_reg < 3) return 3;
         if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
         return int'(height_reg);
      endfunction

      // stored position only: a wrap still pending after a resize does not count
      function bit frame_start();
         return next_column == 0 && next_row == 0;
      endfunction

      function int pending();
         return expected_edges.size();
      endfunction

      function int weight(int mask, int c);
         logic signed [7:0] coefficient;
         coefficient = mask_rows[mask][8*c +: 8];
         return int'(coefficient);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [MASK_ROW_W-1:0] data);
         if (index < REG_FRAME_WIDTH) mask_rows[index] = data;
         else if (index == REG_FRAME_WIDTH) width_reg = data[SIZE_W-1:0];
         else if (index == REG_FRAME_HEIGHT) height_reg = data[SIZE_W-1:0];
      endfunction

      function void accept_pixel(pixel_type px);
         int w, h, col, row, gx, gy;
         edge_result_type res;
         w = span_width();
         h = span_height();
         if (next_column >= w) begin
            next_column = 0;
            next_row++;
         end
         if (next_row >= h) next_row = 0;
         col = next_column;
         row = next_row;

         for (int r = 0; r < 3; r++) begin
            window[r][0] = window[r][1];
            window[r][1] = window[r][2];
         end
         window[0][2] = upper_line[col];
         window[1][2] = lower_line[col];
         window[2][2] = px;
         upper_line[col] = lower_line[col];
         lower_line[col] = px;

         if (row >= 2 && col >= 2) begin
            gx = 0;
            gy = 0;
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  gx += weight(r, c) * int'(window[r][c]);
                  gy += weight(3 + r, c) * int'(window[r][c]);
               end
            end
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            gx = gx + gy;
            if (gx > 255) gx = 255;
            res.magnitude = MAG_W'(gx);
            res.column    = COL_W'(col - 1);
            res.row       = ROW_W'(row - 1);
            res.last      = (row == h - 1) && (col == w - 1);
            expected_edges.push_back(res);
         end

         next_column = col + 1;
         if (next_column >= w) begin
            next_column = 0;
            next_row = row + 1;
            if (next_row >= h) next_row = 0;
         end
      endfunction

      function void compare_result(edge_result_type got);
         edge_result_type want;
         if (expected_edges.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result mag=%0d col=%0d row=%0d last=%0b",
                        got.magnitude, got.column, got.row, got.last);
            return;
         end
         want = expected_edges.pop_front();
         if (got.magnitude !== want.magnitude || got.column !== want.column ||
             got.row !== want.row || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: result mismatch: expected mag=%0d col=%0d row=%0d last=%0b,",
                         " got mag=%0d col=%0d row=%0d last=%0b"},
                        want.magnitude, want.column, want.row, want.last,
                        got.magnitude, got.column, got.row, got.last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_gap_pct;
   int   stall_pct;
   int   quiet_cycles;
   edge_magnitude_board board;

   gem_req_if req_bus ();
   gem_rsp_if rsp_bus ();
   gem_csr_if csr_bus ();

   gradient_edge_magnitude_3x3_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) board.accept_pixel(req_bus.pixel);
         if (rsp_bus.valid && rsp_bus.ready)
            board.compare_result({rsp_bus.magnitude, rsp_bus.out_column,
                                  rsp_bus.out_row, rsp_bus.frame_last});
         if (csr_bus.valid && csr_bus.ready) board.write_reg(csr_bus.index, csr_bus.data);

         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("gradient_edge_magnitude_3x3_core verification failed");
            $finish;
         end
      end
   end

   // every driving task starts and ends just after a falling edge
   task automatic push_pixel(pixel_type px);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.pixel = px;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [MASK_ROW_W-1:0] data);
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data  = data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // hold the stream until every pending magnitude is out, then let the pipe empty
   task automatic settle_results();
      req_bus.valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_masks(mask_style_type style);
      logic [MASK_ROW_W-1:0] row_bits;
      for (int i = 0; i < 6; i++) begin
         if (style == MASK_SOBEL) begin
            case (i)
               0:       row_bits = MASK_X_TOP_RST;
               1:       row_bits = MASK_X_MIDDLE_RST;
               2:       row_bits = MASK_X_BOTTOM_RST;
               3:       row_bits = MASK_Y_TOP_RST;
               4:       row_bits = MASK_Y_MIDDLE_RST;
               default: row_bits = MASK_Y_BOTTOM_RST;
            endcase
         end else begin
            for (int c = 0; c < 3; c++) begin
               case (style)
                  MASK_SMALL: row_bits[8*c +: 8] = 8'($urandom_range(4)) - 8'd2;
                  MASK_EXTREME: begin
                     case ($urandom_range(3))
                        0:       row_bits[8*c +: 8] = 8'h80;
                        1:       row_bits[8*c +: 8] = 8'h7F;
                        2:       row_bits[8*c +: 8] = 8'hFF;
                        default: row_bits[8*c +: 8] = 8'h00;
                     endcase
                  end
                  default: row_bits[8*c +: 8] = 8'($urandom_range(255));
               endcase
            end
         end
         write_register(CSR_IDX_W'(int'(REG_MASK_X_TOP) + i), row_bits);
      end
   endtask

   task automatic reconfigure();
      int limit;
      if ($urandom_range(1)) load_masks(mask_style_type'($urandom_range(3)));
      if ($urandom_range(1)) begin
         // widen only at a frame start: wider rows mid-frame would read unfilled line entries
         limit = board.frame_start() ? SMALL_SIDE : board.span_width();
         if (limit > SMALL_SIDE) limit = SMALL_SIDE;
         if ($urandom_range(7) == 0)
            write_register(REG_FRAME_WIDTH, MASK_ROW_W'($urandom_range(2)));
         else
            write_register(REG_FRAME_WIDTH, MASK_ROW_W'($urandom_range(limit, 3)));
      end
      if ($urandom_range(1)) begin
         if ($urandom_range(7) == 0)
            write_register(REG_FRAME_HEIGHT, MASK_ROW_W'($urandom_range(2)));
         else
            write_register(REG_FRAME_HEIGHT, MASK_ROW_W'($urandom_range(9, 3)));
      end
   endtask

   task automatic run_segment(int count);
      pixel_style_type style;
      int              base;
      pixel_type       px;
      style = pixel_style_type'($urandom_range(2));
      base  = $urandom_range(249);
      repeat (count) begin
         case (style)
            PIXEL_SMOOTH: px = pixel_type'(base + $urandom_range(6));
            PIXEL_BINARY: px = $urandom_range(1) ? 8'hFF : 8'h00;
            default:      px = pixel_type'($urandom_range(255));
         endcase
         push_pixel(px);
         if ($urandom_range(199) == 0) settle_results();
      end
   endtask

   initial begin
      pixel_type step_frame [16];
      pixel_type corner_frame [9];
      int        budget;
      int        count;

      clock         = 1'b0;
      reset         = 1'b1;
      send_gap_pct  = 0;
      stall_pct     = 0;
      quiet_cycles  = 0;
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      board = new();

      step_frame = '{8'h00, 8'h00, 8'hFF, 8'hFF,
                     8'h00, 8'h00, 8'hFF, 8'hFF,
                     8'h00, 8'h00, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 8'h00, 8'h00};
      corner_frame = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'hFF};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default masks on a small frame of hard edges; a spare index must change nothing
      write_register(REG_FRAME_WIDTH, MASK_ROW_W'(4));
      write_register(REG_FRAME_HEIGHT, MASK_ROW_W'(4));
      write_register(CSR_IDX_W'($urandom_range(int'(FIRST_SPARE_INDEX), 2**CSR_IDX_W - 1)),
                     MASK_ROW_W'($urandom));
      foreach (step_frame[i]) push_pixel(step_frame[i]);
      settle_results();

      // extreme coefficients, sizes below the minimum
      write_register(REG_MASK_X_TOP, 24'h7F0080);
      write_register(REG_MASK_X_MIDDLE, 24'h7F0080);
      write_register(REG_MASK_X_BOTTOM, 24'h7F0080);
      write_register(REG_MASK_Y_TOP, 24'h808080);
      write_register(REG_MASK_Y_MIDDLE, 24'h000000);
      write_register(REG_MASK_Y_BOTTOM, 24'h7F7F7F);
      write_register(REG_FRAME_WIDTH, MASK_ROW_W'(2));
      write_register(REG_FRAME_HEIGHT, MASK_ROW_W'(0));
      foreach (corner_frame[i]) push_pixel(corner_frame[i]);

      for (int mode = 0; mode < 3; mode++) begin
         send_gap_pct = (mode == 0) ? 33 : (mode == 1) ? 77 : 0;
         stall_pct    = (mode == 0) ? 77 : (mode == 1) ? 33 : 0;

         if (mode == 2) begin
            // one wide frame run to completion, then the top rows of a frame past the
            // height limit
            settle_results();
            while (!board.frame_start()) push_pixel(pixel_type'($urandom_range(255)));
            settle_results();
            load_masks(MASK_SMALL);
            write_register(REG_FRAME_WIDTH, MASK_ROW_W'(WIDE_SIDE));
            write_register(REG_FRAME_HEIGHT, MASK_ROW_W'($urandom_range(3)));
            run_segment(board.span_width() * board.span_height());
            settle_results();
            write_register(REG_FRAME_WIDTH, MASK_ROW_W'($urandom_range(3)));
            write_register(REG_FRAME_HEIGHT, MASK_ROW_W'(2**SIZE_W - 1));
            run_segment(board.span_width() * TALL_ROWS);
         end

         budget = PIXELS_PER_MODE;
         while (budget > 0) begin
            settle_results();
            reconfigure();
            count = $urandom_range(1, 2 * board.span_width() * board.span_height());
            if (count > budget) count = budget;
            run_segment(count);
            budget -= count;
         end
      end

      settle_results();
      if (board.mismatches == 0)
         $display("gradient_edge_magnitude_3x3_core verification clean");
      else
         $display("gradient_edge_magnitude_3x3_core verification failed");
      $finish;
   end

endmodule
